@@ rtl/core/mtgl_pkg.sv @@
// Shared types, constants and helpers for the multibyte text glyph locator.
package mtgl_pkg;

    localparam int CODE_W       = 8;
    localparam int START_X_W    = 12;
    localparam int OFFSET_W     = 19;
    localparam int DRAW_X_W     = 13;
    localparam int COLUMN_BITS_DEF = 12;

    localparam logic [7:0] GB_LO       = 8'ha1;
    localparam logic [7:0] GB_HI       = 8'hfe;
    localparam logic [7:0] SJ_LEAD1_LO = 8'h81;
    localparam logic [7:0] SJ_LEAD1_HI = 8'h9f;
    localparam logic [7:0] SJ_LEAD2_LO = 8'he0;
    localparam logic [7:0] SJ_LEAD2_HI = 8'hfc;
    localparam logic [7:0] SJ_TR1_LO   = 8'h40;
    localparam logic [7:0] SJ_TR1_HI   = 8'h7e;
    localparam logic [7:0] SJ_TR2_LO   = 8'h80;
    localparam logic [7:0] SJ_TR2_HI   = 8'h9e;
    localparam logic [7:0] SJ_TR3_LO   = 8'h9f;
    localparam logic [7:0] SJ_TR3_HI   = 8'hfc;
    localparam logic [6:0] SJ_ROW2_BASE = 7'd62;
    localparam logic [6:0] SJ_CELL2_BASE = 7'd63;
    localparam logic [13:0] CELLS_PER_ROW = 14'd94;
    localparam logic [OFFSET_W-1:0] JP_BASE = 19'd4096;

    typedef enum logic [1:0] {
        MODE_ASCII  = 2'd0,
        MODE_GB2312 = 2'd1,
        MODE_SJIS   = 2'd2,
        MODE_EUCJP  = 2'd3
    } lang_mode_t;

    typedef enum logic [1:0] {
        STORE_HALF  = 2'd0,
        STORE_GB    = 2'd1,
        STORE_JP    = 2'd2
    } font_store_t;

    typedef enum logic [1:0] {
        KIND_HALF   = 2'd0,
        KIND_WORD   = 2'd1,
        KIND_SPLIT  = 2'd2
    } glyph_kind_t;

    typedef struct packed {
        logic                emit;
        logic                hold_lead;
        logic                drop_lead;
        font_store_t         store;
        logic [OFFSET_W-1:0] offset;
        glyph_kind_t         kind;
        logic                full_width;
        logic                bad;
    } glyph_dec_t;

    function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                      input logic [7:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic is_lead(input lang_mode_t mode, input logic [7:0] b);
        logic r;
        r = 1'b0;
        unique case (mode)
            MODE_GB2312, MODE_EUCJP: r = in_range(b, GB_LO, GB_HI);
            MODE_SJIS: r = in_range(b, SJ_LEAD1_LO, SJ_LEAD1_HI) ||
                           in_range(b, SJ_LEAD2_LO, SJ_LEAD2_HI);
            default: r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/core/mtgl_decode.sv @@
// Byte decoder: classifies a text byte and forms glyph store, offset and kind.
module mtgl_decode (
    input  mtgl_pkg::lang_mode_t  mode,
    input  logic [7:0]            pending_lead,
    input  logic [7:0]            code_byte,
    output mtgl_pkg::glyph_dec_t  dec
);
    import mtgl_pkg::*;

    logic        pend_valid;
    logic        pair;
    logic [7:0]  lead_off;
    logic [6:0]  sj_row;
    logic [6:0]  sj_cell;
    logic        sj_ok;
    logic [13:0] sj_idx;
    logic [7:0]  gb_row8;
    logic [7:0]  gb_cell8;
    logic        gb_ok;
    logic [13:0] gb_idx;
    logic [7:0]  cell8;

    assign pend_valid = (pending_lead != 8'd0);
    assign pair       = (mode != MODE_ASCII) && pend_valid;

    always_comb begin
        if (pending_lead <= SJ_LEAD1_HI) begin
            lead_off = pending_lead - SJ_LEAD1_LO;
            sj_row   = {lead_off[5:0], 1'b0};
        end else begin
            lead_off = pending_lead - SJ_LEAD2_LO;
            sj_row   = {lead_off[5:0], 1'b0} + SJ_ROW2_BASE;
        end
        sj_ok   = 1'b1;
        sj_cell = 7'd0;
        cell8   = 8'd0;
        if (in_range(code_byte, SJ_TR1_LO, SJ_TR1_HI)) begin
            cell8   = code_byte - SJ_TR1_LO;
            sj_cell = cell8[6:0];
        end else if (in_range(code_byte, SJ_TR2_LO, SJ_TR2_HI)) begin
            cell8   = code_byte - SJ_TR2_LO;
            sj_cell = cell8[6:0] + SJ_CELL2_BASE;
        end else if (in_range(code_byte, SJ_TR3_LO, SJ_TR3_HI)) begin
            cell8   = code_byte - SJ_TR3_LO;
            sj_row  = sj_row + 7'd1;
            sj_cell = cell8[6:0];
        end else begin
            sj_ok = 1'b0;
        end
        sj_ok  = sj_ok && is_lead(mode, pending_lead);
        sj_idx = 14'(sj_row) * CELLS_PER_ROW + 14'(sj_cell);
    end

    assign gb_row8  = pending_lead - GB_LO;
    assign gb_cell8 = code_byte - GB_LO;
    assign gb_ok    = is_lead(mode, pending_lead) && in_range(code_byte, GB_LO, GB_HI);
    assign gb_idx   = 14'(gb_row8[6:0]) * CELLS_PER_ROW + 14'(gb_cell8[6:0]);

    always_comb begin
        dec            = '0;
        dec.store      = STORE_HALF;
        dec.kind       = KIND_HALF;
        if (code_byte != 8'd0) begin
            if (!pair) begin
                if ((mode != MODE_ASCII) && is_lead(mode, code_byte)) begin
                    dec.hold_lead = 1'b1;
                end else begin
                    dec.emit   = 1'b1;
                    dec.store  = (mode == MODE_SJIS || mode == MODE_EUCJP) ?
                                 STORE_JP : STORE_HALF;
                    dec.offset = {7'd0, code_byte, 4'd0};
                end
            end else begin
                dec.emit       = 1'b1;
                dec.drop_lead  = 1'b1;
                dec.full_width = 1'b1;
                dec.store      = (mode == MODE_GB2312) ? STORE_GB : STORE_JP;
                dec.kind       = (mode == MODE_GB2312) ? KIND_WORD : KIND_SPLIT;
                unique case (mode)
                    MODE_SJIS: begin
                        dec.bad    = !sj_ok;
                        dec.offset = sj_ok ? (JP_BASE + {sj_idx, 5'd0}) : '0;
                    end
                    MODE_EUCJP: begin
                        dec.bad    = !gb_ok;
                        dec.offset = gb_ok ? (JP_BASE + {gb_idx, 5'd0}) : '0;
                    end
                    default: begin
                        dec.bad    = !gb_ok;
                        dec.offset = gb_ok ? {gb_idx, 5'd0} : '0;
                    end
                endcase
            end
        end
    end

endmodule

@@ rtl/core/multibyte_text_glyph_locator.sv @@
// Multibyte text glyph locator top level.
// Results are registered: a byte's result appears on the m_ side in the cycle after its input transfer.
// Throughput: one byte per cycle while the output is not stalled; decode is a single registered pass.
// Output register holds a result under backpressure; s_tready = !m_tvalid || m_tready.
// Reset (aresetn low, synchronous): mode ASCII, no lead held, column 0, output empty.
module multibyte_text_glyph_locator #(
    parameter int COLUMN_BITS = mtgl_pkg::COLUMN_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,   // lang_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // code_byte[7:0], start_x[19:8], zero pad
    input  logic        s_tuser,    // start_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // glyph_offset[18:0], draw_x[31:19]
    output logic [4:0]  m_tuser     // font_store[1:0], glyph_kind[3:2], bad_trail[4]
);
    import mtgl_pkg::*;

    localparam int DXW = (COLUMN_BITS > DRAW_X_W) ? COLUMN_BITS : DRAW_X_W;

    lang_mode_t             mode_reg;
    logic [7:0]             pending_reg, pending_next;
    logic [COLUMN_BITS-1:0] column_reg, column_next;
    logic [COLUMN_BITS-1:0] col_eff;
    logic                   s_xfer;
    logic [7:0]             code_byte;
    logic [START_X_W-1:0]   start_x;
    glyph_dec_t             dec;
    logic [DXW-1:0]         col_ext, dx_full;

    logic                   m_valid_reg;
    logic [OFFSET_W-1:0]    offset_reg;
    logic [DRAW_X_W-1:0]    draw_x_reg;
    font_store_t            store_reg;
    glyph_kind_t            kind_reg;
    logic                   bad_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign s_xfer    = s_tvalid && s_tready;
    assign code_byte = s_tdata[7:0];
    assign start_x   = s_tdata[19:8];
    assign col_eff   = s_tuser ? COLUMN_BITS'(start_x) : column_reg;

    mtgl_decode u_decode (
        .mode         (mode_reg),
        .pending_lead (pending_reg),
        .code_byte    (code_byte),
        .dec          (dec)
    );

    assign col_ext = DXW'(col_eff);
    assign dx_full = dec.full_width ? (col_ext - DXW'(8)) : col_ext;

    always_comb begin
        pending_next = pending_reg;
        if (dec.hold_lead) begin
            pending_next = code_byte;
        end else if (dec.drop_lead) begin
            pending_next = 8'd0;
        end
        column_next = (code_byte != 8'd0) ? (col_eff + COLUMN_BITS'(8)) : col_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= MODE_ASCII;
            pending_reg <= 8'd0;
            column_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                mode_reg <= lang_mode_t'(cfg_data);
            end
            if (s_xfer) begin
                pending_reg <= pending_next;
                column_reg  <= column_next;
                m_valid_reg <= dec.emit;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            offset_reg <= dec.offset;
            draw_x_reg <= dx_full[DRAW_X_W-1:0];
            store_reg  <= dec.store;
            kind_reg   <= dec.kind;
            bad_reg    <= dec.bad;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {draw_x_reg, offset_reg};
    assign m_tuser  = {bad_reg, kind_reg, store_reg};

endmodule
